>>> hdl/tic_gated_event_ring_defines.svh
// ----------------------------------------------------------------------------
// tic_gated_event_ring_defines.svh
// Assertion macros used by the checker file of the event ring.
// ----------------------------------------------------------------------------
`ifndef TIC_GATED_EVENT_RING_DEFINES_SVH
`define TIC_GATED_EVENT_RING_DEFINES_SVH

// same-cycle implication
`define TGE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// next-cycle implication
`define TGE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

>>> hdl/tge_pkg.sv
// ----------------------------------------------------------------------------
// tge_pkg
// Types, codes and sizes shared by the tic-gated event ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tge_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] FUNC_PUSH = 2'd0;
   localparam logic [1:0] FUNC_TAP  = 2'd1;
   localparam logic [1:0] FUNC_POP  = 2'd2;

   localparam logic signed [31:0] TIC_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic [1:0]          func;
      logic                event_pressed;
      logic [7:0]          key_code;
      logic signed [31:0]  current_tic;
   } req_type;

   typedef struct packed {
      logic                got_event;
      logic                out_pressed;
      logic [7:0]          out_key;
      logic [1:0]          dropped_count;
   } rsp_type;

   typedef struct packed {
      logic                pressed;
      logic [7:0]          key;
      logic signed [31:0]  tic;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      S_IDLE,
      S_OP,
      S_TAP2,
      S_POP,
      S_DONE
   } ctl_state_type;

   typedef struct packed {
      logic load_item;
      logic push_first;
      logic push_second;
      logic pop_check;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       rsp_busy;
   } ctl_status_type;

endpackage

>>> hdl/tic_gated_event_ring.sv
// ----------------------------------------------------------------------------
// tic_gated_event_ring
// Ring queue of key events gated by tic, drop-oldest on overflow.
// ----------------------------------------------------------------------------
//  channel  | ports          | payload  | role
//  ---------+----------------+----------+-----------------------------
//  req      | valid / stall  | req_type | push event, tap or pop item
//  rsp      | valid / stall  | rsp_type | one result item per req item
//
//  Push event and unused code pass S_OP and S_DONE after accept; tap adds
//  S_TAP2 and pop adds S_POP. The single write port of the entry RAM makes
//  a tap two write steps, and the registered RAM read adds one step to a pop.
//  A new item is accepted while the previous result waits on rsp_stall.
//  Reset clears the ring pointers and holds req_stall; RAM is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tic_gated_event_ring
   import tge_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctl_cmd_type        cmd;
   ctl_status_type     status;
   logic               ram_wr_en;
   logic [PTR_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [PTR_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   tge_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tge_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   tge_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

>>> hdl/tge_ram.sv
// ----------------------------------------------------------------------------
// tge_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tge_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/tge_ctl.sv
// ----------------------------------------------------------------------------
// tge_ctl
// Sequencer of the event ring: walks one item through its steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tge_ctl
   import tge_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  ctl_status_type status,
   output ctl_cmd_type    cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = reset;
            if (req_valid && !reset) begin
               cmd.load_item = 1'b1;
               state_in      = S_OP;
            end
         end
         S_OP: begin
            case (status.func)
               FUNC_PUSH: begin
                  cmd.push_first = 1'b1;
                  state_in       = S_DONE;
               end
               FUNC_TAP: begin
                  cmd.push_first = 1'b1;
                  state_in       = S_TAP2;
               end
               FUNC_POP: begin
                  state_in = S_POP;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_TAP2: begin
            cmd.push_second = 1'b1;
            state_in        = S_DONE;
         end
         S_POP: begin
            cmd.pop_check = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/tge_dp.sv
// ----------------------------------------------------------------------------
// tge_dp
// Datapath of the event ring: item latch, ring pointers, result and
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tge_dp
   import tge_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  req_type            req_data,
   input  ctl_cmd_type        cmd,
   output ctl_status_type     status,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   output logic               ram_wr_en,
   output logic [PTR_W-1:0]   ram_wr_addr,
   output logic [ENTRY_W-1:0] ram_wr_data,
   output logic [PTR_W-1:0]   ram_rd_addr,
   input  logic [ENTRY_W-1:0] ram_rd_data
);

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] s);
      return (s == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
   endfunction

   req_type           item_ff;
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic              got_ff, got_in;
   logic              opr_ff, opr_in;
   logic [7:0]        key_ff, key_in;
   logic [1:0]        drop_ff, drop_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;

   logic              push_en;
   logic [PTR_W-1:0]  wr_next;
   logic              full;
   logic signed [31:0] later_tic;
   entry_type         push_entry;
   entry_type         head;
   logic              pop_ok;

   assign push_en   = cmd.push_first | cmd.push_second;
   assign wr_next   = ring_next(wr_ff);
   assign full      = (wr_next == rd_ff);
   assign later_tic = (item_ff.current_tic == TIC_MAX) ? TIC_MAX
                                                      : item_ff.current_tic + 32'sd1;
   assign head      = entry_type'(ram_rd_data);
   assign pop_ok    = (rd_ff != wr_ff) &&
                      ($signed(head.tic) <= $signed(item_ff.current_tic));

   always_comb begin
      push_entry.key = item_ff.key_code;
      if (cmd.push_second) begin
         push_entry.pressed = 1'b0;
         push_entry.tic     = later_tic;
      end else begin
         push_entry.pressed = (item_ff.func == FUNC_TAP) ? 1'b1 : item_ff.event_pressed;
         push_entry.tic     = item_ff.current_tic;
      end
   end

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      got_in  = got_ff;
      opr_in  = opr_ff;
      key_in  = key_ff;
      drop_in = drop_ff;
      if (cmd.load_item) begin
         got_in  = 1'b0;
         opr_in  = 1'b0;
         key_in  = '0;
         drop_in = '0;
      end
      if (push_en) begin
         wr_in = wr_next;
         if (full) begin
            rd_in   = ring_next(rd_ff);
            drop_in = drop_ff + 2'd1;
         end
      end
      if (cmd.pop_check && pop_ok) begin
         rd_in  = ring_next(rd_ff);
         got_in = 1'b1;
         opr_in = head.pressed;
         key_in = head.key;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff        <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_data;
      end
      got_ff  <= got_in;
      opr_ff  <= opr_in;
      key_ff  <= key_in;
      drop_ff <= drop_in;
      if (cmd.load_rsp) begin
         rsp_ff.got_event     <= got_ff;
         rsp_ff.out_pressed   <= opr_ff;
         rsp_ff.out_key       <= key_ff;
         rsp_ff.dropped_count <= drop_ff;
      end
   end

   assign ram_wr_en   = push_en;
   assign ram_wr_addr = wr_ff;
   assign ram_wr_data = ENTRY_W'(push_entry);
   assign ram_rd_addr = rd_ff;

   assign status.func     = item_ff.func;
   assign status.rsp_busy = rsp_valid_ff & rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hdl/tge_checker.sv
// ----------------------------------------------------------------------------
// tge_checker
// Port-level checks of the event ring, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tic_gated_event_ring_defines.svh"

module tge_checker
   import tge_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `TGE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `TGE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `TGE_ASSERT_IMP(a_no_event_zero, clock, reset, rsp_valid && !rsp_data.got_event, !rsp_data.out_pressed && rsp_data.out_key == 8'd0)
   `TGE_ASSERT_IMP(a_pop_no_drop, clock, reset, rsp_valid && rsp_data.got_event, rsp_data.dropped_count == 2'd0)
   `TGE_ASSERT_IMP(a_drop_range, clock, reset, rsp_valid, rsp_data.dropped_count != 2'd3)

endmodule

bind tic_gated_event_ring tge_checker u_tge_checker (.*);
